>>> rtl/mssfl_pkg.sv
// Package for the shared free-list multi-stack: defaults, codes and state type.
`timescale 1ns / 1ps

package mssfl_pkg;

    // Default geometry
    localparam int DEF_NUM_STACKS = 4;
    localparam int DEF_DEPTH      = 16;

    // Fixed field widths
    localparam int VALUE_W  = 32;
    localparam int SEL_W    = 2;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_POP_RD,
        ST_POP_WR
    } state_t;

endpackage

>>> rtl/mssfl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module mssfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/multi_stack_shared_free_list.sv
// Top level: several linked stacks sharing one data store through a free list.
//
//  channel | direction | handshake           | words
//  --------+-----------+---------------------+------------------------------
//  in      | input     | in_valid / in_ready | op, stack_sel, push_value
//  out     | output    | out_valid/out_ready | status, pop_value
//
// A push reads the top and the link of the free head, then writes back; a pop
// reads the top, reads link and data at that slot, then writes back. The
// serial read of the link RAM behind the top RAM gives the pop its extra step.
// Reset clears the sequencer, free head, top valid bits and fill count; no
// clearing pass is needed, untouched slots are tracked by the fill count.
// A finished word waits in the output register; the write-back stalls only
// while that register is still full and out_ready is low.
`timescale 1ns / 1ps

module multi_stack_shared_free_list #(
    parameter int NUM_STACKS = mssfl_pkg::DEF_NUM_STACKS,
    parameter int DEPTH      = mssfl_pkg::DEF_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic [mssfl_pkg::SEL_W-1:0]          stack_sel,
    input  logic signed [mssfl_pkg::VALUE_W-1:0] push_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mssfl_pkg::STATUS_W-1:0]       status,
    output logic signed [mssfl_pkg::VALUE_W-1:0] pop_value
);

    import mssfl_pkg::*;

    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(DEPTH);

    // Sequencer and item registers
    state_t               state_reg, state_next;
    logic [SEL_W-1:0]     sel_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [AW-1:0]        slot_reg, slot_next;
    logic                 empty_reg, empty_next;
    logic                 op_reg;

    // Free list state
    logic [LW-1:0]        fh_reg, fh_next;
    logic [LW-1:0]        hw_reg, hw_next;
    logic [NUM_STACKS-1:0] vld_reg, vld_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [VALUE_W-1:0]   pop_value_reg, pop_value_next;

    // RAM ports
    logic                 top_we, top_re;
    logic [SW-1:0]        top_waddr, top_raddr;
    logic [LW-1:0]        top_wdata, top_q;
    logic                 link_we, link_re;
    logic [AW-1:0]        link_waddr, link_raddr;
    logic [LW-1:0]        link_wdata, link_q;
    logic                 data_we, data_re;
    logic [AW-1:0]        data_raddr;
    logic [VALUE_W-1:0]   data_q;

    // Decoded conditions
    logic                 accept;
    logic                 fin_ok;
    logic [SW-1:0]        sel_idx;
    logic                 in_range;
    logic [LW-1:0]        top_cur;
    logic                 push_full;
    logic                 pop_empty;
    logic [LW-1:0]        push_link;

    assign sel_idx   = SW'(sel_reg);
    assign in_range  = (32'(sel_reg) < 32'(NUM_STACKS));
    assign top_cur   = (in_range && vld_reg[sel_idx]) ? top_q : NULL_LINK;
    assign push_full = !in_range || (fh_reg >= NULL_LINK);
    assign pop_empty = !in_range || (top_cur >= NULL_LINK);
    // A free head at the fill count was never linked; its next free slot is the one above it
    assign push_link = (fh_reg == hw_reg) ? LW'(hw_reg + 1'b1) : link_q;
    assign fin_ok    = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (op == OP_POP) ? ST_POP_RD : ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (fin_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP_RD:
            begin
                state_next = ST_POP_WR;
            end
            ST_POP_WR:
            begin
                if (fin_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: RAM controls and register updates
    always_comb
    begin
        in_ready       = 1'b0;
        top_re         = 1'b0;
        top_raddr      = SW'(stack_sel);
        top_we         = 1'b0;
        top_waddr      = sel_idx;
        top_wdata      = fh_reg;
        link_re        = 1'b0;
        link_raddr     = fh_reg[AW-1:0];
        link_we        = 1'b0;
        link_waddr     = fh_reg[AW-1:0];
        link_wdata     = top_cur;
        data_re        = 1'b0;
        data_raddr     = top_cur[AW-1:0];
        data_we        = 1'b0;
        slot_next      = slot_reg;
        empty_next     = empty_reg;
        fh_next        = fh_reg;
        hw_next        = hw_reg;
        vld_next       = vld_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        pop_value_next = pop_value_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                // Fetch selected top and link of free head
                top_re   = accept;
                link_re  = accept;
            end
            ST_PUSH:
            begin
                if (fin_ok)
                begin
                    out_valid_next = 1'b1;
                    pop_value_next = '0;
                    if (push_full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        status_next       = STATUS_OK;
                        data_we           = 1'b1;
                        link_we           = 1'b1;
                        top_we            = 1'b1;
                        vld_next[sel_idx] = 1'b1;
                        fh_next           = push_link;
                        if (fh_reg == hw_reg)
                        begin
                            hw_next = LW'(hw_reg + 1'b1);
                        end
                    end
                end
            end
            ST_POP_RD:
            begin
                // Read link and data of the top slot
                empty_next = pop_empty;
                slot_next  = top_cur[AW-1:0];
                link_raddr = top_cur[AW-1:0];
                link_re    = !pop_empty;
                data_re    = !pop_empty;
            end
            ST_POP_WR:
            begin
                top_wdata  = link_q;
                link_waddr = slot_reg;
                link_wdata = fh_reg;
                if (fin_ok)
                begin
                    out_valid_next = 1'b1;
                    if (empty_reg)
                    begin
                        status_next    = STATUS_EMPTY;
                        pop_value_next = '0;
                    end
                    else
                    begin
                        status_next    = STATUS_OK;
                        pop_value_next = data_q;
                        top_we         = 1'b1;
                        link_we        = 1'b1;
                        fh_next        = LW'(slot_reg);
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fh_reg        <= '0;
            hw_reg        <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fh_reg        <= fh_next;
            hw_reg        <= hw_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op;
            sel_reg <= stack_sel;
            val_reg <= push_value;
        end
        slot_reg      <= slot_next;
        empty_reg     <= empty_next;
        status_reg    <= status_next;
        pop_value_reg <= pop_value_next;
    end

    // Top-of-stack pointers
    mssfl_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_STACKS),
        .AW    (SW)
    ) u_top_ram (
        .clk   (clk),
        .we    (top_we),
        .waddr (top_waddr),
        .wdata (top_wdata),
        .re    (top_re),
        .raddr (top_raddr),
        .rdata (top_q)
    );

    // Links, shared by stacks and free list
    mssfl_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_q)
    );

    // Stored values; only written on push, at the free head slot
    mssfl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we && (op_reg == OP_PUSH)),
        .waddr (fh_reg[AW-1:0]),
        .wdata (val_reg),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_q)
    );

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign pop_value = pop_value_reg;

endmodule

>>> rtl/mssfl_checker.sv
// Port-level checker for the multi-stack block, bound to the top level.
`timescale 1ns / 1ps

module mssfl_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 op,
    input logic [mssfl_pkg::SEL_W-1:0]          stack_sel,
    input logic signed [mssfl_pkg::VALUE_W-1:0] push_value,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [mssfl_pkg::STATUS_W-1:0]       status,
    input logic signed [mssfl_pkg::VALUE_W-1:0] pop_value
);

    import mssfl_pkg::*;

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pop_value))
        else $error("output word changed while stalled");

    // Only defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_FULL ||
                       status == STATUS_EMPTY))
        else $error("undefined status code");

    // Failed operations return zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> pop_value == '0)
        else $error("non-zero value on failed operation");

    // One word at a time: no accept in the cycle after an accept
    a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous word in progress");

endmodule

bind multi_stack_shared_free_list mssfl_checker u_mssfl_checker (.*);
